// ----- design/edma_pkg.sv -----
// ----------------------------------------------------------------------------
// edma_pkg
// Shared widths and constants for the echo distance moving average block.
// ----------------------------------------------------------------------------
package edma_pkg;

	localparam int ECHO_W          = 16;
	localparam int DIST_W          = 19;
	localparam int CFG_W           = 5;
	localparam int MAX_SAMPLES_DEF = 16;

	localparam int DIST_MUL_W = 11;
	localparam int PROD_W     = ECHO_W + DIST_MUL_W;
	localparam logic [DIST_MUL_W-1:0] DIST_MUL = DIST_MUL_W'(1114);
	localparam int DIST_SHIFT = 8;

endpackage

// ----- design/edma_if.sv -----
// ----------------------------------------------------------------------------
// edma_echo_if / edma_result_if
// Valid/ready channels for echo widths in and averaged distances out.
// ----------------------------------------------------------------------------
interface edma_echo_if;
	import edma_pkg::*;

	logic              valid;
	logic              ready;
	logic [ECHO_W-1:0] echo_us;

	modport source (output valid, output echo_us, input ready);
	modport sink   (input valid, input echo_us, output ready);
endinterface

interface edma_result_if;
	import edma_pkg::*;

	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] distance_q8;
	logic              valid_res;

	modport source (output valid, output distance_q8, output valid_res, input ready);
	modport sink   (input valid, input distance_q8, input valid_res, output ready);
endinterface

// ----- design/echo_distance_moving_average.sv -----
// ----------------------------------------------------------------------------
// echo_distance_moving_average
// Converts echo widths to distance and averages them over a sample ring.
// ----------------------------------------------------------------------------
//  channel   dir  handshake       payload
//  echo      in   valid/ready     echo_us[15:0]
//  result    out  valid/ready     distance_q8[18:0], valid_res
//  cfg       in   cfg_wr_en       cfg_wr_data[4:0] (window size)
//
//  An averaged sample passes the conversion, ring update and bit-serial divider
//  states before its result goes out; the divider gives one quotient bit per cycle.
//  Timeouts and a window of one skip the ring update and the divider.
//  The ring is a single-port memory, read in the cycle before its write-back.
//  A new echo is taken while a finished result still waits on the output.
//  Reset sets the window to one and clears slot, count and total.
// ----------------------------------------------------------------------------
module echo_distance_moving_average #(
	parameter int MAX_SAMPLES = edma_pkg::MAX_SAMPLES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	edma_echo_if.sink                  echo,
	edma_result_if.source              result,
	input  logic                       cfg_wr_en,
	input  logic [edma_pkg::CFG_W-1:0] cfg_wr_data
);
	import edma_pkg::*;

	localparam int SlotW = $clog2(MAX_SAMPLES);
	localparam int CntW  = $clog2(MAX_SAMPLES + 1);
	localparam int TotW  = DIST_W + SlotW;
	localparam int DcW   = $clog2(TotW + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_UPD,
		S_DIV,
		S_OUT
	} state_t;

	state_t              state_q;
	logic [ECHO_W-1:0]   us_q;
	logic [DIST_W-1:0]   dist_s1;
	logic [SlotW-1:0]    slot_s1;
	logic [DIST_W-1:0]   rd_s2;
	logic [CFG_W-1:0]    window_q;
	logic [SlotW-1:0]    write_slot_q;
	logic [CntW-1:0]     fill_q;
	logic [TotW-1:0]     total_q;
	logic [TotW-1:0]     dvd_q;
	logic [CntW-1:0]     rem_q;
	logic [CntW-1:0]     div_q;
	logic [DcW-1:0]      div_cnt_q;
	logic [DIST_W-1:0]   pend_dist_q;
	logic                pend_vld_q;
	logic                out_valid_q;
	logic [DIST_W-1:0]   out_dist_q;
	logic                out_vld_q;
	logic [DIST_W-1:0]   ring [MAX_SAMPLES];

	logic [PROD_W-1:0]   prod;
	logic [DIST_W-1:0]   echo_dist;
	logic [SlotW-1:0]    slot_eff;
	logic [SlotW-1:0]    slot_nx;
	logic                full;
	logic [TotW-1:0]     total_nx;
	logic [CntW-1:0]     fill_nx;
	logic [CntW:0]       trial;
	logic                qbit;
	logic [TotW-1:0]     dvd_nx;
	logic [CFG_W-1:0]    window_wr;
	logic                out_free;
	logic                tmo_clr;

	assign prod      = PROD_W'(us_q) * PROD_W'(DIST_MUL);
	assign echo_dist = DIST_W'(prod >> DIST_SHIFT);

	assign slot_eff = (int'(write_slot_q) >= int'(window_q)) ? '0 : write_slot_q;
	assign slot_nx  = (int'(slot_s1) + 1 >= int'(window_q)) ? '0 : SlotW'(slot_s1 + 1'b1);

	assign full     = int'(fill_q) >= int'(window_q);
	assign total_nx = total_q - (full ? TotW'(rd_s2) : '0) + TotW'(dist_s1);
	assign fill_nx  = full ? fill_q : CntW'(fill_q + 1'b1);

	assign trial  = {rem_q, dvd_q[TotW-1]};
	assign qbit   = trial >= {1'b0, div_q};
	assign dvd_nx = {dvd_q[TotW-2:0], qbit};

	assign tmo_clr = (state_q == S_CONV) && (us_q == '0) && (int'(window_q) > 1);

	always_comb begin
		window_wr = cfg_wr_data;
		if (cfg_wr_data == '0) begin
			window_wr = CFG_W'(1);
		end else if (int'(cfg_wr_data) > MAX_SAMPLES) begin
			window_wr = CFG_W'(MAX_SAMPLES);
		end
	end

	assign out_free = !out_valid_q || result.ready;

	assign echo.ready         = state_q == S_IDLE;
	assign result.valid       = out_valid_q;
	assign result.distance_q8 = out_dist_q;
	assign result.valid_res   = out_vld_q;

	always_ff @(posedge clk) begin
		if (state_q == S_CONV) begin
			rd_s2 <= ring[slot_eff];
		end
		if (state_q == S_UPD) begin
			ring[slot_s1] <= dist_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			window_q     <= CFG_W'(1);
			write_slot_q <= '0;
			fill_q       <= '0;
			total_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (echo.valid) begin
						us_q    <= echo.echo_us;
						state_q <= S_CONV;
					end
				end
				S_CONV: begin
					dist_s1 <= echo_dist;
					slot_s1 <= slot_eff;
					if (us_q == '0) begin
						pend_dist_q <= '0;
						pend_vld_q  <= 1'b0;
						state_q     <= S_OUT;
					end else if (int'(window_q) <= 1) begin
						pend_dist_q <= echo_dist;
						pend_vld_q  <= 1'b1;
						state_q     <= S_OUT;
					end else begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					dvd_q     <= total_nx;
					div_q     <= fill_nx;
					rem_q     <= '0;
					div_cnt_q <= DcW'(TotW);
					state_q   <= S_DIV;
				end
				S_DIV: begin
					rem_q     <= qbit ? CntW'(trial - {1'b0, div_q}) : CntW'(trial);
					dvd_q     <= dvd_nx;
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == DcW'(1)) begin
						pend_dist_q <= dvd_nx[DIST_W-1:0];
						pend_vld_q  <= 1'b1;
						state_q     <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_dist_q  <= pend_dist_q;
						out_vld_q   <= pend_vld_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cfg_wr_en) begin
				window_q <= window_wr;
			end
			if (cfg_wr_en || tmo_clr) begin
				write_slot_q <= '0;
				fill_q       <= '0;
				total_q      <= '0;
			end else if (state_q == S_UPD) begin
				total_q      <= total_nx;
				fill_q       <= fill_nx;
				write_slot_q <= slot_nx;
			end
		end
	end

	a_fill_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fill_q) <= int'(window_q))
		else $error("fill count above window");

	a_slot_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		int'(window_q) > 1 |-> int'(write_slot_q) < int'(window_q))
		else $error("write slot outside window");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> div_q != '0)
		else $error("divide by zero count");

	a_upd_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPD |-> int'(window_q) > 1 && us_q != '0)
		else $error("ring update outside averaging mode");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT && out_free |=> out_valid_q && state_q == S_IDLE)
		else $error("result transfer lost");

endmodule

// ----- dv/tb_echo_distance_moving_average.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_echo_distance_moving_average
// Drives echo widths through the valid/ready input channel and checks each
// averaged distance against an in-bench model of the conversion, sample ring,
// running total and divide. Covers window of one, timeouts, register clamping
// and long random runs over many window sizes, most with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_echo_distance_moving_average;
	import edma_pkg::*;

	localparam int RING_DEPTH  = MAX_SAMPLES_DEF;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_WAIT  = 40;

	typedef struct packed {
		logic [DIST_W-1:0] distance_q8;
		logic              valid_res;
	} avg_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic             cfg_wr_en;
	logic [CFG_W-1:0] cfg_wr_data;

	edma_echo_if   echo_ch ();
	edma_result_if res_ch ();

	echo_distance_moving_average dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.echo       (echo_ch),
		.result     (res_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #10 clk = ~clk;

	// model state
	logic [DIST_W-1:0] ring_mdl [RING_DEPTH];
	int window_mdl;
	int slot_mdl;
	int fill_mdl;
	int total_mdl;

	avg_result_t expected_avg_q[$];

	int  cycle_cnt;
	int  mismatches;
	int  echoes_sent;
	int  timeouts_sent;
	int  results_checked;
	int  ready_hold;
	int  ready_roll;
	bit  send_idle_en;
	bit  sink_stall_en;

	function automatic avg_result_t predict_average(logic [ECHO_W-1:0] us);
		avg_result_t r;
		int dist_v;
		int slot;
		r = '0;
		if (us == '0) begin
			if (window_mdl > 1) begin
				slot_mdl  = 0;
				fill_mdl  = 0;
				total_mdl = 0;
			end
			return r;
		end
		dist_v = (int'(us) * int'(DIST_MUL)) >> DIST_SHIFT;
		r.valid_res = 1'b1;
		if (window_mdl <= 1) begin
			r.distance_q8 = DIST_W'(dist_v);
			return r;
		end
		slot = slot_mdl;
		if (slot >= window_mdl)
			slot = 0;
		if (fill_mdl >= window_mdl)
			total_mdl -= int'(ring_mdl[slot]);
		else
			fill_mdl++;
		ring_mdl[slot] = DIST_W'(dist_v);
		total_mdl += dist_v;
		slot++;
		if (slot >= window_mdl)
			slot = 0;
		slot_mdl = slot;
		r.distance_q8 = DIST_W'(total_mdl / fill_mdl);
		return r;
	endfunction

	function automatic int pick_gap();
		int roll;
		if (!send_idle_en)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [ECHO_W-1:0] pick_echo();
		case ($urandom_range(0, 24))
			0:       return '0;
			1:       return '1;
			2, 3:    return ECHO_W'($urandom_range(1, 64));
			default: return ECHO_W'($urandom_range(1, 65535));
		endcase
	endfunction

	// called at a rising edge; leaves valid high after the transfer
	task automatic send_echo(input logic [ECHO_W-1:0] us);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			echo_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		echo_ch.valid   <= 1'b1;
		echo_ch.echo_us <= us;
		do @(posedge clk); while (!echo_ch.ready);
		expected_avg_q.push_back(predict_average(us));
		echoes_sent++;
		if (us == '0)
			timeouts_sent++;
	endtask

	task automatic wait_results_drained();
		echo_ch.valid <= 1'b0;
		while (expected_avg_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_window(input int value);
		int v;
		wait_results_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= CFG_W'(value);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		v = value & ((1 << CFG_W) - 1);
		if (v == 0)
			v = 1;
		if (v > RING_DEPTH)
			v = RING_DEPTH;
		window_mdl = v;
		slot_mdl   = 0;
		fill_mdl   = 0;
		total_mdl  = 0;
	endtask

	task automatic test_passthrough();
		send_echo(16'd1);
		send_echo(16'hFFFF);
		send_echo(16'd0);
		send_echo(16'hAAAA);
		send_echo(16'h5555);
		send_echo(16'd59);
		send_echo(16'h8000);
	endtask

	task automatic test_timeout_clear();
		write_window(4);
		send_echo(16'd100);
		send_echo(16'd200);
		send_echo(16'd0);
		send_echo(16'd300);
		repeat (5) send_echo(16'hFFFF);
	endtask

	task automatic test_window_clamp();
		write_window(0);
		send_echo(16'd1234);
		send_echo(16'd0);
		write_window(31);
		send_echo(16'hFFFF);
		send_echo(16'd1);
		send_echo(16'd40000);
	endtask

	task automatic test_random_windows();
		int windows [12] = '{2, 16, 31, 1, 5, 0, 8, 17, 3, 12, 7, 15};
		int n;
		for (int p = 0; p < 12; p++) begin
			write_window(windows[p]);
			send_idle_en  = (p % 4) != 2;
			sink_stall_en = (p % 4) != 2;
			n = $urandom_range(70, 100);
			for (int i = 0; i < n; i++) begin
				if (p == 6 && i == n / 2)
					wait_results_drained();
				send_echo(pick_echo());
			end
		end
		send_idle_en  = 1'b1;
		sink_stall_en = 1'b1;
	endtask

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (!sink_stall_en) begin
			res_ch.ready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold--;
		end else begin
			ready_roll = $urandom_range(0, 99);
			if (ready_roll < 55) begin
				res_ch.ready <= 1'b1;
				ready_hold = $urandom_range(0, 8);
			end else if (ready_roll < 93) begin
				res_ch.ready <= 1'b0;
				ready_hold = $urandom_range(0, 3);
			end else begin
				res_ch.ready <= 1'b0;
				ready_hold = $urandom_range(20, 60);
			end
		end
	end

	always @(posedge clk) begin
		avg_result_t exp_r;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_avg_q.size() == 0) begin
				$error("unexpected result: distance_q8 %0d, valid_res %0d",
					res_ch.distance_q8, res_ch.valid_res);
				mismatches++;
			end else begin
				exp_r = expected_avg_q.pop_front();
				results_checked++;
				if (res_ch.distance_q8 !== exp_r.distance_q8) begin
					$error("distance_q8 mismatch: expected %0d, actual %0d",
						exp_r.distance_q8, res_ch.distance_q8);
					mismatches++;
				end
				if (res_ch.valid_res !== exp_r.valid_res) begin
					$error("valid_res mismatch: expected %0d, actual %0d",
						exp_r.valid_res, res_ch.valid_res);
					mismatches++;
				end
			end
		end
	end

	initial begin
		arst_n          <= 1'b0;
		cfg_wr_en       <= 1'b0;
		cfg_wr_data     <= '0;
		echo_ch.valid   <= 1'b0;
		echo_ch.echo_us <= '0;
		cycle_cnt       = 0;
		mismatches      = 0;
		echoes_sent     = 0;
		timeouts_sent   = 0;
		results_checked = 0;
		ready_hold      = 0;
		send_idle_en    = 1'b1;
		sink_stall_en   = 1'b1;
		window_mdl      = 1;
		slot_mdl        = 0;
		fill_mdl        = 0;
		total_mdl       = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_passthrough();
		test_timeout_clear();
		test_window_clamp();
		test_random_windows();

		wait_results_drained();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Run covered %0d echo transfers (%0d timeouts), %0d results checked,",
			echoes_sent, timeouts_sent, results_checked);
		$display("windows of 1 to 16 including clamped writes of 0, 17 and 31.");
		if (mismatches == 0 && expected_avg_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
